@@ rtl/c2dmac_pkg.sv @@
package c2dmac_pkg;

    // Widths of the configuration registers.
    localparam int HEIGHT_W   = 11;
    localparam int WIDTH_W    = 9;
    localparam int CH_W       = 5;
    localparam int KER_W      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    // Widths of the item fields.
    localparam int WIDX_W      = 14;
    localparam int DATA_W      = 16;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int ROW_W       = 10;
    localparam int COL_W       = 8;
    localparam int OCH_W       = 4;
    localparam int SUM_W       = 48;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 72;

    // Item kinds carried on the input tuser.
    localparam logic CMD_WEIGHT = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_HEIGHT  = 3'd0,
        REG_IMAGE_WIDTH   = 3'd1,
        REG_IN_CHANNELS   = 3'd2,
        REG_OUT_CHANNELS  = 3'd3,
        REG_KERNEL_HEIGHT = 3'd4,
        REG_KERNEL_WIDTH  = 3'd5
    } cfg_reg_t;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_KSETUP,
        S_MAC,
        S_DRAIN,
        S_EMIT
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic            accept;
        logic            k_start;
        logic [CH_W-1:0] k;
        logic            issue;
        logic            step_q;
        logic            step_dj;
        logic            step_di;
        logic            load_out;
        logic            last_k;
    } c2dmac_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic             hit;
        logic             pipe_busy;
        logic             out_free;
        logic [CH_W-1:0]  in_ch;
        logic [CH_W-1:0]  out_ch;
        logic [KER_W-1:0] kh;
        logic [KER_W-1:0] kw;
    } c2dmac_status_t;

endpackage

@@ rtl/c2dmac_ctrl.sv @@
module c2dmac_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  c2dmac_pkg::c2dmac_status_t status,
    output c2dmac_pkg::c2dmac_cmd_t    cmd
);
    import c2dmac_pkg::*;

    ctrl_state_t      state_reg, state_next;
    logic [CH_W-1:0]  k_reg, k_next;
    logic [CH_W-1:0]  q_reg, q_next;
    logic [KER_W-1:0] dj_reg, dj_next;
    logic [KER_W-1:0] di_reg, di_next;

    // State and loop counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            q_reg     <= '0;
            dj_reg    <= '0;
            di_reg    <= '0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
            q_reg     <= q_next;
            dj_reg    <= dj_next;
            di_reg    <= di_next;
        end
    end

    // Next state and commands. The window loop runs input channel fastest,
    // then kernel column, then kernel row, one product per cycle.
    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        q_next     = q_reg;
        dj_next    = dj_reg;
        di_next    = di_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        cmd.k      = k_reg;
        cmd.last_k = (k_reg == status.out_ch - CH_W'(1));
        case (state_reg)
            S_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid && status.hit) begin
                    k_next     = '0;
                    state_next = S_KSETUP;
                end
            end
            S_KSETUP: begin
                cmd.k_start = 1'b1;
                q_next      = '0;
                dj_next     = '0;
                di_next     = '0;
                state_next  = S_MAC;
            end
            S_MAC: begin
                cmd.issue = 1'b1;
                if (q_reg != status.in_ch - CH_W'(1)) begin
                    cmd.step_q = 1'b1;
                    q_next     = q_reg + CH_W'(1);
                end else if (dj_reg != status.kw - KER_W'(1)) begin
                    cmd.step_dj = 1'b1;
                    q_next      = '0;
                    dj_next     = dj_reg + KER_W'(1);
                end else if (di_reg != status.kh - KER_W'(1)) begin
                    cmd.step_di = 1'b1;
                    q_next      = '0;
                    dj_next     = '0;
                    di_next     = di_reg + KER_W'(1);
                end else begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!status.pipe_busy) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    if (cmd.last_k) begin
                        state_next = S_IDLE;
                    end else begin
                        k_next     = k_reg + CH_W'(1);
                        state_next = S_KSETUP;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    // A product is issued only after the accumulator was cleared for this sum.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MAC) |-> ($past(state_reg) == S_KSETUP || $past(state_reg) == S_MAC))
        else $error("product issued without accumulator setup");
    // Loop counters stay inside the configured window.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MAC) |-> (q_reg < status.in_ch && dj_reg < status.kw
                                  && di_reg < status.kh))
        else $error("window loop counter out of range");
    // Output channel counter stays below the configured count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT) |-> (k_reg < status.out_ch))
        else $error("output channel counter out of range");
`endif

endmodule

@@ rtl/c2dmac_dp.sv @@
module c2dmac_dp #(
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_IN_CH  = 16,
    parameter int MAX_OUT_CH = 16,
    parameter int MAX_KERNEL = 7
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic [c2dmac_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  logic                                   s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [c2dmac_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                   m_tlast,
    input  logic                                   cfg_valid,
    input  logic [c2dmac_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [c2dmac_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  c2dmac_pkg::c2dmac_cmd_t                cmd,
    output c2dmac_pkg::c2dmac_status_t             status
);
    import c2dmac_pkg::*;

    localparam int W_DEPTH   = MAX_KERNEL * MAX_KERNEL * MAX_IN_CH * MAX_OUT_CH;
    localparam int L_DEPTH   = MAX_KERNEL * MAX_WIDTH * MAX_IN_CH;
    localparam int WA_W      = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
    localparam int LA_W      = (L_DEPTH > 1) ? $clog2(L_DEPTH) : 1;
    localparam int RING_W    = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int W_STEP_Q  = MAX_OUT_CH;
    localparam int W_STEP_DJ = MAX_IN_CH * MAX_OUT_CH;
    localparam int W_STEP_DI = MAX_KERNEL * MAX_IN_CH * MAX_OUT_CH;
    localparam int L_ROW     = MAX_WIDTH * MAX_IN_CH;

    function automatic logic [31:0] clamp_cfg(input logic [31:0] v, input int hi);
        logic [31:0] r;
        if (v < 32'd1) begin
            r = 32'd1;
        end else if (v > 32'(hi)) begin
            r = 32'(hi);
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Input fields.
    logic [WIDX_W-1:0] widx;
    logic [DATA_W-1:0] din;
    logic              sample_acc;
    logic              weight_acc;
    assign widx       = s_tdata[WIDX_W-1:0];
    assign din        = s_tdata[WIDX_W +: DATA_W];
    assign sample_acc = cmd.accept && (s_tuser == CMD_SAMPLE);
    assign weight_acc = cmd.accept && (s_tuser == CMD_WEIGHT);

    // Configuration registers, clamped on write.
    logic [HEIGHT_W-1:0] height_reg;
    logic [WIDTH_W-1:0]  width_reg;
    logic [CH_W-1:0]     in_ch_reg;
    logic [CH_W-1:0]     out_ch_reg;
    logic [KER_W-1:0]    kh_reg;
    logic [KER_W-1:0]    kw_reg;
    logic                cfg_hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            height_reg <= HEIGHT_W'(1);
            width_reg  <= WIDTH_W'(1);
            in_ch_reg  <= CH_W'(1);
            out_ch_reg <= CH_W'(1);
            kh_reg     <= KER_W'(1);
            kw_reg     <= KER_W'(1);
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_IMAGE_HEIGHT:  height_reg <=
                    HEIGHT_W'(clamp_cfg(32'(cfg_data[HEIGHT_W-1:0]), MAX_HEIGHT));
                REG_IMAGE_WIDTH:   width_reg  <=
                    WIDTH_W'(clamp_cfg(32'(cfg_data[WIDTH_W-1:0]), MAX_WIDTH));
                REG_IN_CHANNELS:   in_ch_reg  <=
                    CH_W'(clamp_cfg(32'(cfg_data[CH_W-1:0]), MAX_IN_CH));
                REG_OUT_CHANNELS:  out_ch_reg <=
                    CH_W'(clamp_cfg(32'(cfg_data[CH_W-1:0]), MAX_OUT_CH));
                REG_KERNEL_HEIGHT: kh_reg     <=
                    KER_W'(clamp_cfg(32'(cfg_data[KER_W-1:0]), MAX_KERNEL));
                REG_KERNEL_WIDTH:  kw_reg     <=
                    KER_W'(clamp_cfg(32'(cfg_data[KER_W-1:0]), MAX_KERNEL));
                default: begin
                end
            endcase
        end
    end

    // A valid write to any of the six defined register indexes starts a new image.
    always_comb begin
        case (cfg_reg_t'(cfg_index))
            REG_IMAGE_HEIGHT, REG_IMAGE_WIDTH, REG_IN_CHANNELS,
            REG_OUT_CHANNELS, REG_KERNEL_HEIGHT, REG_KERNEL_WIDTH: cfg_hit = cfg_valid;
            default: cfg_hit = 1'b0;
        endcase
    end

    // Sample position, with the ring row of the line store beside it.
    logic [HEIGHT_W-1:0] row_reg;
    logic [WIDTH_W-1:0]  col_reg;
    logic [CH_W-1:0]     ch_reg;
    logic [RING_W-1:0]   ring_reg;
    logic                ch_wrap, col_wrap, row_wrap;
    logic                hit;

    assign ch_wrap  = (32'(ch_reg) + 32'd1) >= 32'(in_ch_reg);
    assign col_wrap = (32'(col_reg) + 32'd1) >= 32'(width_reg);
    assign row_wrap = (32'(row_reg) + 32'd1) >= 32'(height_reg);
    assign hit      = (s_tuser == CMD_SAMPLE) && ch_wrap
                      && ((32'(row_reg) + 32'd1) >= 32'(kh_reg))
                      && ((32'(col_reg) + 32'd1) >= 32'(kw_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_hit) begin
            row_reg  <= '0;
            col_reg  <= '0;
            ch_reg   <= '0;
            ring_reg <= '0;
        end else if (sample_acc) begin
            if (!ch_wrap) begin
                ch_reg <= ch_reg + CH_W'(1);
            end else begin
                ch_reg <= '0;
                if (!col_wrap) begin
                    col_reg <= col_reg + WIDTH_W'(1);
                end else begin
                    col_reg <= '0;
                    if (row_wrap) begin
                        row_reg  <= '0;
                        ring_reg <= '0;
                    end else begin
                        row_reg  <= row_reg + HEIGHT_W'(1);
                        ring_reg <= (32'(ring_reg) == 32'(MAX_KERNEL - 1)) ? '0
                                    : ring_reg + RING_W'(1);
                    end
                end
            end
        end
    end

    // Window origin, latched on every accepted sample, so it holds the window closed by the last one.
    logic [ROW_W-1:0]  r0_reg;
    logic [COL_W-1:0]  c0_reg;
    logic [LA_W-1:0]   c0mic_reg;
    logic [RING_W-1:0] r0ring_reg;
    logic [LA_W-1:0]   r0base_reg;
    logic [31:0]       r0ring_tmp;
    logic [31:0]       r0ring_fix;
    logic [31:0]       slot_tmp;

    assign r0ring_tmp = 32'(ring_reg) + 32'(MAX_KERNEL) + 32'd1 - 32'(kh_reg);
    assign r0ring_fix = (r0ring_tmp >= 32'(MAX_KERNEL)) ? r0ring_tmp - 32'(MAX_KERNEL)
                                                         : r0ring_tmp;
    assign slot_tmp   = 32'(ring_reg) * 32'(L_ROW) + 32'(col_reg) * 32'(MAX_IN_CH)
                        + 32'(ch_reg);

    always_ff @(posedge aclk) begin
        if (sample_acc) begin
            r0_reg     <= ROW_W'(32'(row_reg) + 32'd1 - 32'(kh_reg));
            c0_reg     <= COL_W'(32'(col_reg) + 32'd1 - 32'(kw_reg));
            c0mic_reg  <= LA_W'((32'(col_reg) + 32'd1 - 32'(kw_reg)) * 32'(MAX_IN_CH));
            r0ring_reg <= r0ring_fix[RING_W-1:0];
            r0base_reg <= LA_W'(r0ring_fix * 32'(L_ROW));
        end
    end

    // Read address walk over the window.
    logic [WA_W-1:0]   w_di_reg, w_dj_reg, w_addr_reg;
    logic [RING_W-1:0] l_rr_reg;
    logic [LA_W-1:0]   l_base_reg, l_col_reg, l_addr_reg;
    logic [WA_W-1:0]   w_di_step, w_dj_step;
    logic [LA_W-1:0]   l_col_step, l_base_step, l_col_row;
    logic              rr_wrap;

    assign w_di_step   = w_di_reg + WA_W'(W_STEP_DI);
    assign w_dj_step   = w_dj_reg + WA_W'(W_STEP_DJ);
    assign l_col_step  = l_col_reg + LA_W'(MAX_IN_CH);
    assign rr_wrap     = (32'(l_rr_reg) == 32'(MAX_KERNEL - 1));
    assign l_base_step = rr_wrap ? '0 : l_base_reg + LA_W'(L_ROW);
    assign l_col_row   = l_base_step + c0mic_reg;

    always_ff @(posedge aclk) begin
        if (cmd.k_start) begin
            w_di_reg   <= WA_W'(cmd.k);
            w_dj_reg   <= WA_W'(cmd.k);
            w_addr_reg <= WA_W'(cmd.k);
            l_rr_reg   <= r0ring_reg;
            l_base_reg <= r0base_reg;
            l_col_reg  <= r0base_reg + c0mic_reg;
            l_addr_reg <= r0base_reg + c0mic_reg;
        end else if (cmd.step_q) begin
            w_addr_reg <= w_addr_reg + WA_W'(W_STEP_Q);
            l_addr_reg <= l_addr_reg + LA_W'(1);
        end else if (cmd.step_dj) begin
            w_dj_reg   <= w_dj_step;
            w_addr_reg <= w_dj_step;
            l_col_reg  <= l_col_step;
            l_addr_reg <= l_col_step;
        end else if (cmd.step_di) begin
            w_di_reg   <= w_di_step;
            w_dj_reg   <= w_di_step;
            w_addr_reg <= w_di_step;
            l_rr_reg   <= rr_wrap ? '0 : l_rr_reg + RING_W'(1);
            l_base_reg <= l_base_step;
            l_col_reg  <= l_col_row;
            l_addr_reg <= l_col_row;
        end
    end

    // Weight store: written by weight items, read once per product.
    logic [DATA_W-1:0] weight_mem [W_DEPTH];
    logic [DATA_W-1:0] w_rd_reg;
    logic [31:0]       widx_ext;
    assign widx_ext = 32'(widx);

    always_ff @(posedge aclk) begin
        if (weight_acc && (widx_ext < 32'(W_DEPTH))) begin
            weight_mem[widx_ext[WA_W-1:0]] <= din;
        end
        if (cmd.issue) begin
            w_rd_reg <= weight_mem[w_addr_reg];
        end
    end

    // Line store: a ring of kernel rows, written by sample items.
    logic [DATA_W-1:0] line_mem [L_DEPTH];
    logic [DATA_W-1:0] l_rd_reg;

    always_ff @(posedge aclk) begin
        if (sample_acc) begin
            line_mem[slot_tmp[LA_W-1:0]] <= din;
        end
        if (cmd.issue) begin
            l_rd_reg <= line_mem[l_addr_reg];
        end
    end

    // Multiply and accumulate pipeline.
    logic                     rd_v_reg, mul_v_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SUM_W-1:0]  acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_v_reg  <= 1'b0;
            mul_v_reg <= 1'b0;
        end else begin
            rd_v_reg  <= cmd.issue;
            mul_v_reg <= rd_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= $signed(w_rd_reg) * $signed(l_rd_reg);
        if (cmd.k_start) begin
            acc_reg <= '0;
        end else if (mul_v_reg) begin
            acc_reg <= acc_reg + SUM_W'(prod_reg);
        end
    end

    // Output register.
    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic                   out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_data_reg <= {2'b00, acc_reg, cmd.k[OCH_W-1:0], c0_reg, r0_reg};
            out_last_reg <= cmd.last_k;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // Status to the controller.
    always_comb begin
        status           = '0;
        status.hit       = hit;
        status.pipe_busy = rd_v_reg | mul_v_reg;
        status.out_free  = !out_valid_reg || m_tready;
        status.in_ch     = in_ch_reg;
        status.out_ch    = out_ch_reg;
        status.kh        = kh_reg;
        status.kw        = kw_reg;
    end

`ifndef ASSERT_OFF
    // Products reach the product register in the cycle after their operands are read.
    assert property (@(posedge aclk) disable iff (!aresetn)
        mul_v_reg |-> $past(rd_v_reg))
        else $error("product without matching store read");
    // A sum is loaded only after every product has been accumulated.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> !(rd_v_reg || mul_v_reg))
        else $error("sum loaded while products are in flight");
    // The accumulator is never cleared while products are in flight.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.k_start |-> !(rd_v_reg || mul_v_reg))
        else $error("accumulator cleared with products in flight");
    // No item is taken while a window is being worked on.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |-> !(rd_v_reg || mul_v_reg || cmd.issue))
        else $error("item accepted during window work");
`endif

endmodule

@@ rtl/conv2d_multichannel_window_mac.sv @@
// Direct 2D convolution (stride 1, no padding) over height-width-channel images.
// Weight items (tuser 0) write the weight store; sample items (tuser 1) arrive
// in raster order, channel fastest. When a sample closes a kernel window the
// block emits one 48-bit signed Q32.16 sum per output channel, tlast on the last one.
// One multiply-accumulate unit works the window one product at a time, since each store
// has a single read port: kernel_height * kernel_width * in_channels products for each
// output channel. Other items do not drop input ready. Input ready is low while a window
// is being summed. A write to a defined register index restarts the image at row 0,
// column 0, channel 0.
module conv2d_multichannel_window_mac #(
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_IN_CH  = 16,
    parameter int MAX_OUT_CH = 16,
    parameter int MAX_KERNEL = 7
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // weight_index [13:0], data_value [29:14], zero fill [31:30]
    input  logic [c2dmac_pkg::IN_TDATA_W-1:0]   s_tdata,
    // cmd [0]
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // out_row [9:0], out_col [17:10], out_channel [21:18], sum_value [69:22],
    // zero fill [71:70]
    output logic [c2dmac_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic                                m_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [c2dmac_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [c2dmac_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import c2dmac_pkg::*;

    c2dmac_cmd_t    cmd;
    c2dmac_status_t status;

    assign cfg_ready = 1'b1;

    c2dmac_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    c2dmac_dp #(
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_IN_CH  (MAX_IN_CH),
        .MAX_OUT_CH (MAX_OUT_CH),
        .MAX_KERNEL (MAX_KERNEL)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
